/* sv/wavp_pkg.sv */
// package with tags, limits, result kinds and parse phases for the wav header parser
`timescale 1ns / 1ps

package wavp_pkg;

	localparam logic [31:0] TAG_WAVE = 32'h45564157;
	localparam logic [31:0] TAG_FMT  = 32'h20746d66;
	localparam logic [31:0] TAG_DATA = 32'h61746164;
	localparam logic [31:0] TAG_LIST = 32'h5453494c;
	localparam logic [31:0] TAG_FACT = 32'h74636166;

	localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
	localparam logic [31:0] FMT_MAX_LEN  = 32'd100;
	localparam logic [31:0] DATA_MIN_LEN = 32'd256;

	localparam logic [31:0] HDR_TAG_START = 32'd8;
	localparam logic [31:0] HDR_LEN       = 32'd12;
	localparam logic [31:0] CHDR_TAG_LEN  = 32'd4;
	localparam logic [31:0] CHDR_LEN      = 32'd8;

	localparam logic [31:0] FMT_POS_CODING = 32'd0;
	localparam logic [31:0] FMT_POS_CHAN   = 32'd2;
	localparam logic [31:0] FMT_POS_RATE0  = 32'd4;
	localparam logic [31:0] FMT_POS_RATE3  = 32'd7;
	localparam logic [31:0] FMT_POS_BITS   = 32'd14;

	localparam int OUT_DATA_W = 96;

	typedef enum logic [1:0] {
		KIND_SAMPLE     = 2'd0,
		KIND_HEADER_OK  = 2'd1,
		KIND_BAD_FORMAT = 2'd2,
		KIND_SHORT_DATA = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_CHUNK  = 6'b000010,
		PH_FMT    = 6'b000100,
		PH_SKIP   = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

endpackage

/* sv/wav_header_parse_and_pcm_extract_core.sv */
// top level: byte-wise wav header parser and 8-bit pcm sample extractor
`timescale 1ns / 1ps
// usage
// input stream: one file byte per word on s_axis_tdata, s_axis_tuser marks the
// first byte of a new file and restarts parsing, s_axis_tlast marks the final byte.
// output stream: zero or one result word per input word; m_axis_tuser carries the
// result kind (sample, header accepted, invalid format, data chunk too short) and
// m_axis_tdata the samples, their valid flags, the kept format and the data size.
// a result is shown on the output in the cycle after its byte is taken.
// throughput: one byte per cycle while the output is not stalled, set by the single
// parse step between the state registers and the output register.
// a stalled receiver holds the output register; the input stays ready while that
// register is empty or is being taken in the same cycle, else it waits.
// reset clears the parse state to waiting for a file header and empties the
// output register; no clearing pass is needed.
module wav_header_parse_and_pcm_extract_core
	import wavp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // file_byte
	input  logic                  s_axis_tuser,  // new_file
	input  logic                  s_axis_tlast,  // last_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// sample_main[7:0], sample_second[15:8], main_valid[16], second_valid[17],
	// channels[19:18], bits_per_sample[24:20], sample_rate[56:25],
	// data_size[88:57], zero fill[95:89]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]            m_axis_tuser   // result_kind
);

	phase_t      phase_q, cur_phase, phase_n;
	logic [31:0] cnt_q, cur_cnt, cnt_n, cnt_inc;
	logic [31:0] tag_q, cur_tag, tag_n;
	logic [31:0] len_q, cur_len, len_n;
	logic [1:0]  ch_q, cur_ch, ch_n;
	logic [4:0]  bits_q, cur_bits, bits_n;
	logic [31:0] rate_q, cur_rate, rate_n;
	logic [1:0]  frame_q, cur_frame, frame_n;
	logic        bad_q, cur_bad, bad_n;

	logic        res_valid;
	kind_t       res_kind;
	logic [7:0]  res_main, res_second;
	logic        res_mv, res_sv;
	logic [31:0] res_dsize;

	logic        in_acc;
	logic        out_valid_q;
	kind_t       out_kind_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [7:0]  b;

	assign b = s_axis_tdata;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		// restart on new file
		cur_phase = s_axis_tuser ? PH_HEADER : phase_q;
		cur_cnt   = s_axis_tuser ? 32'd0 : cnt_q;
		cur_tag   = s_axis_tuser ? 32'd0 : tag_q;
		cur_len   = s_axis_tuser ? 32'd0 : len_q;
		cur_ch    = s_axis_tuser ? 2'd0 : ch_q;
		cur_bits  = s_axis_tuser ? 5'd0 : bits_q;
		cur_rate  = s_axis_tuser ? 32'd0 : rate_q;
		cur_frame = s_axis_tuser ? 2'd0 : frame_q;
		cur_bad   = s_axis_tuser ? 1'b0 : bad_q;

		phase_n = cur_phase;
		cnt_n   = cur_cnt;
		tag_n   = cur_tag;
		len_n   = cur_len;
		ch_n    = cur_ch;
		bits_n  = cur_bits;
		rate_n  = cur_rate;
		frame_n = cur_frame;
		bad_n   = cur_bad;
		cnt_inc = cur_cnt + 32'd1;

		res_valid  = 1'b0;
		res_kind   = KIND_SAMPLE;
		res_main   = 8'd0;
		res_second = 8'd0;
		res_mv     = 1'b0;
		res_sv     = 1'b0;
		res_dsize  = 32'd0;

		case (cur_phase)
			PH_HEADER: begin
				if (cur_cnt >= HDR_TAG_START) begin
					tag_n = {b, cur_tag[31:8]};
				end
				cnt_n = cnt_inc;
				if (cnt_inc == HDR_LEN) begin
					if (tag_n != TAG_WAVE) begin
						res_valid = 1'b1;
						res_kind  = KIND_BAD_FORMAT;
						phase_n   = PH_DONE;
					end else begin
						phase_n = PH_CHUNK;
						cnt_n   = 32'd0;
						tag_n   = 32'd0;
						len_n   = 32'd0;
					end
				end
			end
			PH_CHUNK: begin
				if (cur_cnt < CHDR_TAG_LEN) begin
					tag_n = {b, cur_tag[31:8]};
				end else begin
					len_n = {b, cur_len[31:8]};
				end
				cnt_n = cnt_inc;
				if (cnt_inc == CHDR_LEN) begin
					cnt_n = 32'd0;
					if (tag_n == TAG_FMT) begin
						if (len_n > FMT_MAX_LEN || len_n < FMT_MIN_LEN) begin
							res_valid = 1'b1;
							res_kind  = KIND_BAD_FORMAT;
							phase_n   = PH_DONE;
						end else begin
							bad_n   = 1'b0;
							phase_n = PH_FMT;
						end
					end else if (tag_n == TAG_DATA) begin
						res_valid = 1'b1;
						res_dsize = len_n;
						if (len_n < DATA_MIN_LEN) begin
							res_kind = KIND_SHORT_DATA;
							phase_n  = PH_DONE;
						end else begin
							res_kind = KIND_HEADER_OK;
							frame_n  = 2'd0;
							phase_n  = PH_DATA;
						end
					end else if (tag_n == TAG_LIST || tag_n == TAG_FACT) begin
						if (len_n == 32'd0) begin
							phase_n = PH_CHUNK;
							tag_n   = 32'd0;
							len_n   = 32'd0;
						end else begin
							phase_n = PH_SKIP;
						end
					end else begin
						res_valid = 1'b1;
						res_kind  = KIND_BAD_FORMAT;
						phase_n   = PH_DONE;
					end
				end
			end
			PH_FMT: begin
				if (cur_cnt == FMT_POS_CODING) begin
					if (b != 8'd1) begin
						bad_n = 1'b1;
					end
				end else if (cur_cnt == FMT_POS_CHAN) begin
					if (b == 8'd1 || b == 8'd2) begin
						ch_n = b[1:0];
					end else begin
						bad_n = 1'b1;
					end
				end else if (cur_cnt >= FMT_POS_RATE0 && cur_cnt <= FMT_POS_RATE3) begin
					rate_n = {b, cur_rate[31:8]};
				end else if (cur_cnt == FMT_POS_BITS) begin
					if (b == 8'd8 || b == 8'd16) begin
						bits_n = b[4:0];
					end else begin
						bad_n = 1'b1;
					end
				end
				cnt_n = cnt_inc;
				if (cnt_inc >= cur_len) begin
					if (bad_n) begin
						res_valid = 1'b1;
						res_kind  = KIND_BAD_FORMAT;
						phase_n   = PH_DONE;
					end else begin
						phase_n = PH_CHUNK;
						cnt_n   = 32'd0;
						tag_n   = 32'd0;
						len_n   = 32'd0;
					end
				end
			end
			PH_SKIP: begin
				cnt_n = cnt_inc;
				if (cnt_inc == cur_len) begin
					phase_n = PH_CHUNK;
					cnt_n   = 32'd0;
					tag_n   = 32'd0;
					len_n   = 32'd0;
				end
			end
			PH_DATA: begin
				if (cur_bits == 5'd16 && (cur_ch == 2'd1 || cur_ch == 2'd2)) begin
					if (cur_frame == 2'd1) begin
						res_valid = 1'b1;
						res_main  = b[7] ? 8'd0 : b;
						res_mv    = 1'b1;
					end
					frame_n = cur_frame + 2'd1;
					if (cur_ch == 2'd1) begin
						frame_n[1] = 1'b0;
					end
				end else if (cur_bits == 5'd8 && cur_ch == 2'd2) begin
					res_valid = 1'b1;
					if (cur_frame == 2'd0) begin
						res_main = b;
						res_mv   = 1'b1;
					end else begin
						res_second = b;
						res_sv     = 1'b1;
					end
					frame_n = {1'b0, ~cur_frame[0]};
				end else if (cur_bits == 5'd8 && cur_ch == 2'd1) begin
					res_valid  = 1'b1;
					res_main   = b;
					res_second = b;
					res_mv     = 1'b1;
					res_sv     = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// short file
		if (s_axis_tlast) begin
			if (!res_valid && (phase_n == PH_HEADER || phase_n == PH_CHUNK ||
			                   phase_n == PH_FMT || phase_n == PH_SKIP)) begin
				res_valid = 1'b1;
				res_kind  = KIND_BAD_FORMAT;
			end
			phase_n = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= 32'd0;
			tag_q   <= 32'd0;
			len_q   <= 32'd0;
			ch_q    <= 2'd0;
			bits_q  <= 5'd0;
			rate_q  <= 32'd0;
			frame_q <= 2'd0;
			bad_q   <= 1'b0;
		end else if (in_acc) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			tag_q   <= tag_n;
			len_q   <= len_n;
			ch_q    <= ch_n;
			bits_q  <= bits_n;
			rate_q  <= rate_n;
			frame_q <= frame_n;
			bad_q   <= bad_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && res_valid) begin
			out_kind_q <= res_kind;
			out_data_q <= {7'd0, res_dsize, rate_n, bits_n, ch_n, res_sv, res_mv,
			               res_second, res_main};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

`ifndef SYNTHESIS
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && in_acc && !s_axis_tuser) |-> !res_valid)
		else $error("result produced after end of file");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tlast) |=> (phase_q == PH_DONE))
		else $error("final byte did not end parsing");

	a_sample_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_kind == KIND_SAMPLE) |-> (res_mv || res_sv))
		else $error("sample result without a valid output");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res_valid) |=> m_axis_tvalid)
		else $error("result not loaded into output register");

	a_no_ready_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while output register is stalled");
`endif

endmodule
